// ===== rtl/core/swrm_pkg.sv =====
// Package for the stack with running median: constants and opcode/status codes.
`timescale 1ns / 1ps
package swrm_pkg;
  localparam int unsigned VALUE_BITS_DEF  = 16;
  localparam int unsigned BLOCK_SIZE_DEF  = 256;
  localparam int unsigned STACK_DEPTH_DEF = 4096;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
endpackage

// ===== rtl/core/stack_with_running_median_unit.sv =====
// Top level: LIFO stack with a histogram-based median query.
`timescale 1ns / 1ps
// Steps: push reads and writes back the counts (S_RD, S_UPD); pop first reads the stack (S_PRD,
//   S_PWAIT); peek scans block totals, then histogram entries; one item at a time, in_stall_o
//   is high while an item is at work. The median scan reads each block total, then each
//   histogram entry (registered read, then add/compare), through one read port per memory.
// Reset: after rst_ni rises a clearing pass zeroes histogram and block totals, one entry a
//   cycle; no item is accepted during it.
module stack_with_running_median_unit #(
  parameter int unsigned VALUE_BITS  = swrm_pkg::VALUE_BITS_DEF,
  parameter int unsigned BLOCK_SIZE  = swrm_pkg::BLOCK_SIZE_DEF,
  parameter int unsigned STACK_DEPTH = swrm_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] push_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] result_value_o
);
  localparam int unsigned NUM_VALUES = 1 << VALUE_BITS;
  localparam int unsigned NUM_BLOCKS = (NUM_VALUES + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int unsigned VW = VALUE_BITS;
  localparam int unsigned BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned OW = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
  localparam int unsigned SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_PRD   = 11'b00000000100,  // stack read for pop
    S_PWAIT = 11'b00000001000,
    S_RD    = 11'b00000010000,  // histogram/total read issued
    S_UPD   = 11'b00000100000,  // write back updated counts
    S_BRD   = 11'b00001000000,  // block total read issued
    S_BCHK  = 11'b00010000000,
    S_HRD   = 11'b00100000000,
    S_HCHK  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [VW-1:0] stack_mem [STACK_DEPTH];
  logic [CW-1:0] hist_mem  [NUM_VALUES];
  logic [CW-1:0] blk_mem   [NUM_BLOCKS];

  logic [CW-1:0] count_q;
  logic [VW-1:0] val_q;          // value being pushed/popped, or clear address
  logic          is_push_q;
  logic [CW-1:0] rank_q, seen_q;
  logic [BW-1:0] blk_q;
  logic [OW:0]   off_q;
  logic [VW-1:0] stk_rd_q;
  logic [CW-1:0] hist_rd_q, blk_rd_q;
  logic [1:0]    status_q;
  logic [15:0]   result_q;
  logic          out_valid_q;

  // shared adder/compare
  logic [CW-1:0] add_b;
  logic [CW:0]   sum;
  logic          sum_gt_rank;
  assign add_b       = state_q == S_BCHK ? blk_rd_q : hist_rd_q;
  assign sum         = {1'b0, seen_q} + {1'b0, add_b};
  assign sum_gt_rank = sum > {1'b0, rank_q};

  logic [BW-1:0] vblk;
  assign vblk = BW'(val_q / VW'(BLOCK_SIZE));

  logic [VW-1:0] hscan_addr;
  logic [VW+OW:0] hscan_full;
  assign hscan_full = (VW+OW+1)'(blk_q) * (VW+OW+1)'(BLOCK_SIZE) + (VW+OW+1)'(off_q);
  assign hscan_addr = hscan_full[VW-1:0];

  logic clear_done;
  assign clear_done = (val_q == VW'(NUM_VALUES - 1));

  logic accept;
  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;
  assign accept     = in_valid_i && !in_stall_o;

  // memories; count_q is the free slot on push and, once decremented, the top on pop
  logic [SW-1:0] stk_addr;
  assign stk_addr = SW'(count_q);
  always_ff @(posedge clk_i) begin
    if (accept && opcode_i == swrm_pkg::OP_PUSH && count_q < CW'(STACK_DEPTH)) begin
      stack_mem[stk_addr] <= VW'(push_value_i);
    end
    stk_rd_q <= stack_mem[stk_addr];
  end

  logic          h_we;
  logic [CW-1:0] h_wd, b_wd;
  logic [VW-1:0] h_addr;
  logic [BW-1:0] b_addr;
  always_comb begin
    h_we   = (state_q == S_CLEAR) || (state_q == S_UPD);
    h_addr = (state_q == S_HRD) ? hscan_addr : val_q;
    b_addr = (state_q == S_CLEAR || state_q == S_UPD || state_q == S_RD) ? vblk : blk_q;
    if (state_q == S_CLEAR) begin
      h_wd = '0;
      b_wd = '0;
    end else if (is_push_q) begin
      h_wd = hist_rd_q + CW'(1);
      b_wd = blk_rd_q + CW'(1);
    end else begin
      h_wd = (hist_rd_q != '0) ? hist_rd_q - CW'(1) : hist_rd_q;
      b_wd = (blk_rd_q != '0) ? blk_rd_q - CW'(1) : blk_rd_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hist_mem[h_addr] <= h_wd;
      blk_mem[b_addr]  <= b_wd;
    end
    hist_rd_q <= hist_mem[h_addr];
    blk_rd_q  <= blk_mem[b_addr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clear_done) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (opcode_i)
            swrm_pkg::OP_PUSH: state_d = (count_q < CW'(STACK_DEPTH)) ? S_RD : S_OUT;
            swrm_pkg::OP_POP:  state_d = (count_q != '0) ? S_PRD : S_OUT;
            swrm_pkg::OP_PEEK: state_d = (count_q != '0) ? S_BRD : S_OUT;
            default:           state_d = S_OUT;
          endcase
        end
      end
      S_PRD:   state_d = S_PWAIT;
      S_PWAIT: state_d = S_RD;
      S_RD:    state_d = S_UPD;
      S_UPD:   state_d = S_OUT;
      S_BRD:   state_d = S_BCHK;
      S_BCHK: begin
        if (sum_gt_rank) state_d = S_HRD;
        else if (blk_q == BW'(NUM_BLOCKS - 1)) state_d = S_OUT;
        else state_d = S_BRD;
      end
      S_HRD:   state_d = S_HCHK;
      S_HCHK: begin
        if (sum_gt_rank || off_q == (OW+1)'(BLOCK_SIZE - 1) ||
            hscan_addr == VW'(NUM_VALUES - 1)) state_d = S_OUT;
        else state_d = S_HRD;
      end
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      count_q     <= '0;
      val_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: val_q <= val_q + VW'(1);
        S_IDLE: begin
          if (accept) begin
            val_q <= VW'(push_value_i);
            if (opcode_i == swrm_pkg::OP_PUSH && count_q < CW'(STACK_DEPTH))
              count_q <= count_q + CW'(1);
            if (opcode_i == swrm_pkg::OP_POP && count_q != '0)
              count_q <= count_q - CW'(1);
          end
        end
        S_PWAIT: val_q <= stk_rd_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        // only on accept: the previous result may still be waiting on the output
        if (accept) begin
          is_push_q <= (opcode_i == swrm_pkg::OP_PUSH);
          rank_q    <= (count_q - CW'(1)) >> 1;
          seen_q    <= '0;
          blk_q     <= '0;
          off_q     <= '0;
          status_q  <= swrm_pkg::ST_OK;
          result_q  <= '0;
          if (opcode_i == swrm_pkg::OP_PUSH && count_q >= CW'(STACK_DEPTH))
            status_q <= swrm_pkg::ST_FULL;
          if ((opcode_i == swrm_pkg::OP_POP || opcode_i == swrm_pkg::OP_PEEK) &&
              count_q == '0)
            status_q <= swrm_pkg::ST_EMPTY;
        end
      end
      S_PWAIT: result_q <= 16'(stk_rd_q);
      S_BCHK: begin
        if (!sum_gt_rank) begin
          seen_q <= sum[CW-1:0];
          blk_q  <= blk_q + BW'(1);
        end
      end
      S_HCHK: begin
        seen_q <= sum[CW-1:0];
        off_q  <= off_q + (OW+1)'(1);
        if (sum_gt_rank) result_q <= 16'(hscan_addr);
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_value_o = result_q;
endmodule

// ===== rtl/core/swrm_checker.sv =====
// Port-level checker for the stack with running median, bound to the top level.
`timescale 1ns / 1ps
module swrm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [15:0] result_value_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_value_o))
    else $error("output item changed while stalled");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != swrm_pkg::ST_OK |-> result_value_o == 16'd0)
    else $error("error item carries nonzero value");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted while previous at work");
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("bad status");
endmodule

bind stack_with_running_median_unit swrm_checker u_swrm_checker (.*);
